@@ rtl/cdgs_pkg.sv @@
// shared types, constants and the glyph font for the clock digit grid sequencer
// no dependencies; imported by every module of the block

package cdgs_pkg;

  localparam int unsigned HoldW = 16;
  localparam int unsigned GridW = 15;
  localparam int unsigned StepW = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_DIGIT_HOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COLON_HOLD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COLUMN_HOLD = 2'd2;

  localparam logic [HoldW-1:0] DIGIT_HOLD_RST = 16'd750;
  localparam logic [HoldW-1:0] COLON_HOLD_RST = 16'd600;
  localparam logic [HoldW-1:0] COLUMN_HOLD_RST = 16'd200;

  localparam logic [StepW-1:0] STEP_FIRST = 3'd0;
  localparam logic [StepW-1:0] STEP_COLON = 3'd2;
  localparam logic [StepW-1:0] STEP_LAST = 3'd4;

  localparam logic [3:0] GLYPH_COLON = 4'd10;
  localparam logic [GridW-1:0] COLUMN_BITS = 15'h0421;

  typedef struct packed {
    logic       hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
  } digits_t;

  function automatic logic [GridW-1:0] font_glyph(input logic [3:0] idx);
    logic [GridW-1:0] g;
    case (idx)
      4'd0:    g = 15'h7E3F;
      4'd1:    g = 15'h03E0;
      4'd2:    g = 15'h76B7;
      4'd3:    g = 15'h7EB5;
      4'd4:    g = 15'h7C9C;
      4'd5:    g = 15'h5EBD;
      4'd6:    g = 15'h5EBF;
      4'd7:    g = 15'h7E10;
      4'd8:    g = 15'h7EBF;
      4'd9:    g = 15'h7E9C;
      4'd10:   g = 15'h0140;
      default: g = '0;
    endcase
    return g;
  endfunction

  // 24-hour value (any 5-bit code) to 12-hour digits, zero shown as 12
  function automatic digits_t split_time(input logic [4:0] hours, input logic [5:0] minutes);
    digits_t    d;
    logic [4:0] h;
    logic [2:0] mt;
    logic [5:0] tens_x10;
    if (hours >= 5'd24) begin
      h = hours - 5'd24;
    end else if (hours >= 5'd12) begin
      h = hours - 5'd12;
    end else begin
      h = hours;
    end
    if (h == 5'd0) begin
      h = 5'd12;
    end
    if (minutes >= 6'd60) mt = 3'd6;
    else if (minutes >= 6'd50) mt = 3'd5;
    else if (minutes >= 6'd40) mt = 3'd4;
    else if (minutes >= 6'd30) mt = 3'd3;
    else if (minutes >= 6'd20) mt = 3'd2;
    else if (minutes >= 6'd10) mt = 3'd1;
    else mt = 3'd0;
    tens_x10 = {mt, 3'b000} + {2'b00, mt, 1'b0};
    d.hour_tens = (h >= 5'd10);
    d.hour_ones = d.hour_tens ? 4'(h - 5'd10) : h[3:0];
    d.minute_tens = mt;
    d.minute_ones = 4'(minutes - tens_x10);
    return d;
  endfunction

endpackage

@@ rtl/cdgs_pattern.sv @@
// grid pattern lookup: column bar in draw mode, font glyph in time mode
// depends on cdgs_pkg

module cdgs_pattern
  import cdgs_pkg::*;
(
  input  logic             draw_i,
  input  logic [StepW-1:0] step_i,
  input  digits_t          digits_i,
  output logic [GridW-1:0] grid_o
);

  logic [3:0] glyph;

  always_comb begin
    case (step_i)
      3'd0:    glyph = {3'b000, digits_i.hour_tens};
      3'd1:    glyph = digits_i.hour_ones;
      3'd2:    glyph = GLYPH_COLON;
      3'd3:    glyph = {1'b0, digits_i.minute_tens};
      default: glyph = digits_i.minute_ones;
    endcase
  end

  assign grid_o = draw_i ? GridW'(COLUMN_BITS << step_i) : font_glyph(glyph);

endmodule

@@ rtl/clock_digit_grid_sequencer_top.sv @@
// clock digit grid sequencer top level: tick sequencer, hold registers, result register
// depends on cdgs_pkg and cdgs_pattern
//
//   channel | signals                                          | dir
//   in      | in_valid_i in_ready_o time_mode_i hours_now_i    | in
//           | minutes_now_i                                    |
//   out     | out_valid_o out_ready_i grid_pattern_o           | out
//           | in_draw_mode_o sequence_step_o                   |
//   cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i   | in
//
// one tick per clock unless the result stalls; each tick's result shows in the cycle after acceptance
// the single result register sets the rate: a tick is taken whenever it is empty or drains
// reset clears sequencer state and loads the default hold times
// a stalled result holds its beat and stops input only while it waits

module clock_digit_grid_sequencer_top
  import cdgs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               time_mode_i,
  input  logic [4:0]         hours_now_i,
  input  logic [5:0]         minutes_now_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [GridW-1:0]   grid_pattern_o,
  output logic               in_draw_mode_o,
  output logic [StepW-1:0]   sequence_step_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [HoldW-1:0]   cfg_data_i
);

  logic [HoldW-1:0] digit_hold_q, colon_hold_q, column_hold_q;
  logic             draw_q, draw_d;
  logic [StepW-1:0] step_q, step_d;
  logic [HoldW-1:0] hold_q, hold_d;
  digits_t          digits_q, digits_d;
  logic             started_q, started_d;

  logic             out_valid_q;
  logic [GridW-1:0] grid_q;
  logic             draw_out_q;
  logic [StepW-1:0] step_out_q;

  logic             accept;
  logic             seq_start;
  logic [StepW-1:0] step_cur;
  logic [HoldW-1:0] hold_cur;
  logic [HoldW-1:0] limit_raw;
  logic [HoldW:0]   limit;
  logic             done;
  logic [GridW-1:0] grid;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign seq_start   = !started_q;

  always_comb begin
    draw_d    = draw_q;
    digits_d  = digits_q;
    step_cur  = step_q;
    hold_cur  = hold_q;
    if (seq_start) begin
      draw_d   = !time_mode_i;
      step_cur = STEP_FIRST;
      hold_cur = '0;
      if (time_mode_i) begin
        digits_d = split_time(hours_now_i, minutes_now_i);
      end
    end
    if (step_cur > STEP_LAST) begin
      step_cur = STEP_LAST;
    end

    if (draw_d) limit_raw = column_hold_q;
    else if (step_cur == STEP_COLON) limit_raw = colon_hold_q;
    else limit_raw = digit_hold_q;
    limit = (limit_raw == '0) ? (HoldW+1)'(1) : {1'b0, limit_raw};
    done  = ({1'b0, hold_cur} + (HoldW+1)'(1)) >= limit;

    started_d = 1'b1;
    step_d    = step_cur;
    if (done) begin
      hold_d = '0;
      if (step_cur == STEP_LAST || (draw_d == time_mode_i)) begin
        started_d = 1'b0;
      end else begin
        step_d = step_cur + StepW'(1);
      end
    end else begin
      hold_d = hold_cur + HoldW'(1);
    end
  end

  cdgs_pattern u_pattern (
    .draw_i   (draw_d),
    .step_i   (step_cur),
    .digits_i (digits_d),
    .grid_o   (grid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_hold_q  <= DIGIT_HOLD_RST;
      colon_hold_q  <= COLON_HOLD_RST;
      column_hold_q <= COLUMN_HOLD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DIGIT_HOLD:  digit_hold_q  <= cfg_data_i;
        CFG_COLON_HOLD:  colon_hold_q  <= cfg_data_i;
        CFG_COLUMN_HOLD: column_hold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_q    <= 1'b0;
      step_q    <= '0;
      hold_q    <= '0;
      digits_q  <= '0;
      started_q <= 1'b0;
    end else if (accept) begin
      draw_q    <= draw_d;
      step_q    <= step_d;
      hold_q    <= hold_d;
      digits_q  <= digits_d;
      started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      grid_q     <= grid;
      draw_out_q <= draw_d;
      step_out_q <= step_cur;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign grid_pattern_o  = grid_q;
  assign in_draw_mode_o  = draw_out_q;
  assign sequence_step_o = step_out_q;

endmodule

@@ rtl/cdgs_checker.sv @@
// port-level checks for the clock digit grid sequencer, bound to the top level
// depends on cdgs_pkg and clock_digit_grid_sequencer_top

module cdgs_checker
  import cdgs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [GridW-1:0] grid_pattern_o,
  input logic             in_draw_mode_o,
  input logic [StepW-1:0] sequence_step_o
);

  // result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(grid_pattern_o)
      && $stable(sequence_step_o) && $stable(in_draw_mode_o))
    else $error("result beat changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow result register");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sequence_step_o <= STEP_LAST)
    else $error("step out of range");

  a_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_draw_mode_o |-> grid_pattern_o == GridW'(COLUMN_BITS << sequence_step_o))
    else $error("draw beat is not a single column");

  a_colon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_draw_mode_o && sequence_step_o == STEP_COLON
      |-> grid_pattern_o == font_glyph(GLYPH_COLON))
    else $error("colon step shows wrong glyph");

endmodule

bind clock_digit_grid_sequencer_top cdgs_checker u_cdgs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .grid_pattern_o  (grid_pattern_o),
  .in_draw_mode_o  (in_draw_mode_o),
  .sequence_step_o (sequence_step_o)
);
